/* rtl/dhtm_pkg.sv */
// ----------------------------------------------------------------------------
// Timestamp mapper package
// Shared widths, codes and the record that moves from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

package dhtm_pkg;

    // Field widths.
    localparam int SEQ_W      = 32;
    localparam int US_W       = 32;
    localparam int NS_W       = 63;
    localparam int DNS_W      = 42;   // device time in ns, dev_us * 1000 fits in 42 bits
    localparam int WD_W       = 30;
    localparam int SLEW_W     = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 30;

    // Request kinds.
    typedef enum logic [1:0] {
        ACT_PACKET = 2'd0,
        ACT_PRIME  = 2'd1,
        ACT_RESET  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIRE_DELAY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SLEW   = 1'd1;

    // Constants.
    localparam logic [DNS_W-1:0]  NS_PER_US      = 42'd1000;
    localparam logic [SEQ_W-1:0]  BACKWARD_LIMIT = 32'h8000_0000;
    localparam logic [SLEW_W-1:0] SLEW_RESET     = 20'd2000;
    localparam logic [NS_W-1:0]   NS_MAX         = {NS_W{1'b1}};

    // Pre-classified request held in the queue.
    typedef struct packed {
        t_action            action;
        logic [SEQ_W-1:0]   seq;
        logic               has_stamp;
        logic [NS_W-1:0]    cand;      // offset estimate for this request
        logic [DNS_W-1:0]   dev_ns;
        logic [NS_W-1:0]    rx;
    } t_work;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

/* rtl/dhtm_ifs.sv */
// ----------------------------------------------------------------------------
// Timestamp mapper channels
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhtm_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [dhtm_pkg::SEQ_W-1:0] packet_sequence;
    logic                      stamp_valid;
    logic [dhtm_pkg::US_W-1:0] device_time_us;
    logic [dhtm_pkg::NS_W-1:0] receive_time_ns;

    modport source (output valid, action, packet_sequence, stamp_valid,
                    device_time_us, receive_time_ns, input ready);
    modport sink   (input valid, action, packet_sequence, stamp_valid,
                    device_time_us, receive_time_ns, output ready);
endinterface

interface dhtm_out_if;
    logic                      valid;
    logic                      ready;
    logic [dhtm_pkg::NS_W-1:0] sample_time_ns;
    logic                      dropped_duplicate;
    logic                      timing_was_reset;

    modport source (output valid, sample_time_ns, dropped_duplicate,
                    timing_was_reset, input ready);
    modport sink   (input valid, sample_time_ns, dropped_duplicate,
                    timing_was_reset, output ready);
endinterface

interface dhtm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dhtm_pkg::CFG_IDX_W-1:0]  index;
    logic [dhtm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/device_host_timestamp_mapper.sv */
// ----------------------------------------------------------------------------
// Device to host timestamp mapper
// Maps device microsecond stamps onto the host ns clock with slew-limited
// offset tracking, duplicate dropping and strictly increasing sample times.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake    Carries
//  i_in      in         valid/ready  action, sequence, stamp, device and receive times
//  o_out     out        valid/ready  sample time, duplicate flag, timing reset flag
//  i_cfg     in         valid/ready  register index and write data
//
//  One request per cycle is accepted while the output is taken; each request passes
//  the front register, queue, tracking stage and output register in turn.
//  The sequence and offset tracking stage updates its state as each request passes,
//  which sets the one-per-cycle rate; sample ordering works on its result in r_b1.
//  Reset is synchronous and clears all tracking state; the registers reload their
//  reset values. Configuration writes are always ready.
//  An output stall holds the back end; the queue then fills and the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module device_host_timestamp_mapper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dhtm_in_if.sink    i_in,
    dhtm_out_if.source o_out,
    dhtm_cfg_if.sink   i_cfg
);

    logic [dhtm_pkg::WD_W-1:0]    r_wire_delay_ns;
    logic [dhtm_pkg::SLEW_W-1:0]  r_max_slew_ns;

    logic                         push;
    logic                         pop;
    dhtm_pkg::t_work              push_work;
    dhtm_pkg::t_work              head_work;
    dhtm_pkg::t_q_stat            q_stat;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wire_delay_ns <= '0;
            r_max_slew_ns   <= dhtm_pkg::SLEW_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dhtm_pkg::REG_WIRE_DELAY: r_wire_delay_ns <= i_cfg.data[dhtm_pkg::WD_W-1:0];
                dhtm_pkg::REG_MAX_SLEW:   r_max_slew_ns   <= i_cfg.data[dhtm_pkg::SLEW_W-1:0];
            endcase
        end
    end

    dhtm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_wire_delay_ns (r_wire_delay_ns),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_work          (push_work)
    );

    dhtm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_work),
        .i_pop   (pop),
        .o_data  (head_work),
        .o_stat  (q_stat)
    );

    dhtm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_work        (head_work),
        .i_q_stat      (q_stat),
        .i_max_slew_ns (r_max_slew_ns),
        .o_pop         (pop),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire

/* rtl/dhtm_front.sv */
// ----------------------------------------------------------------------------
// Timestamp mapper front end
// Accepts requests, scales the device time and forms the offset estimate.
// ----------------------------------------------------------------------------
`default_nettype none

module dhtm_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    dhtm_in_if.sink                               i_in,
    input  wire logic [dhtm_pkg::WD_W-1:0]        i_wire_delay_ns,
    input  wire dhtm_pkg::t_q_stat                i_q_stat,
    output logic                                  o_push,
    output dhtm_pkg::t_work                       o_work
);

    logic                         r_valid;
    dhtm_pkg::t_action            r_action;
    logic [dhtm_pkg::SEQ_W-1:0]   r_seq;
    logic                         r_has_stamp;
    logic [dhtm_pkg::DNS_W-1:0]   r_dev_ns;
    logic [dhtm_pkg::NS_W-1:0]    r_adj;
    logic [dhtm_pkg::NS_W-1:0]    r_rx;

    logic                         advance;
    logic [dhtm_pkg::DNS_W-1:0]   n_dev_ns;
    logic [dhtm_pkg::NS_W-1:0]    wd_ext;
    logic [dhtm_pkg::NS_W-1:0]    n_adj;
    logic [dhtm_pkg::NS_W-1:0]    dev_ext;

    // The stage moves on when empty or when the queue has room.
    assign advance    = !r_valid || !i_q_stat.full;
    assign i_in.ready = advance;
    assign o_push     = r_valid && !i_q_stat.full;

    // Device time in ns and receive time less the wire delay.
    always_comb begin
        n_dev_ns = dhtm_pkg::DNS_W'(i_in.device_time_us) * dhtm_pkg::NS_PER_US;
        wd_ext   = dhtm_pkg::NS_W'(i_wire_delay_ns);
        n_adj    = (i_in.receive_time_ns > wd_ext) ? i_in.receive_time_ns - wd_ext
                                                   : i_in.receive_time_ns;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in.valid) begin
            r_action    <= dhtm_pkg::t_action'(i_in.action);
            r_seq       <= i_in.packet_sequence;
            r_has_stamp <= i_in.stamp_valid && (i_in.device_time_us != '0);
            r_dev_ns    <= n_dev_ns;
            r_adj       <= n_adj;
            r_rx        <= i_in.receive_time_ns;
        end
    end

    // Offset estimate, floored at zero.
    always_comb begin
        dev_ext          = dhtm_pkg::NS_W'(r_dev_ns);
        o_work.action    = r_action;
        o_work.seq       = r_seq;
        o_work.has_stamp = r_has_stamp;
        o_work.cand      = (r_adj > dev_ext) ? r_adj - dev_ext : '0;
        o_work.dev_ns    = r_dev_ns;
        o_work.rx        = r_rx;
    end

endmodule

`default_nettype wire

/* rtl/dhtm_queue.sv */
// ----------------------------------------------------------------------------
// Timestamp mapper request queue
// Small register queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module dhtm_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire dhtm_pkg::t_work    i_data,
    input  wire logic               i_pop,
    output dhtm_pkg::t_work         o_data,
    output dhtm_pkg::t_q_stat       o_stat
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dhtm_pkg::t_work  r_mem [DEPTH];
    logic [IW-1:0]    r_wr_ptr;
    logic [IW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap at the last entry; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == IW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == IW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) || r_count == CW'($past(r_count) + 1'b1)
                  || CW'(r_count + 1'b1) == $past(r_count)))
        else $error("queue occupancy jumped by more than one");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/dhtm_back.sv */
// ----------------------------------------------------------------------------
// Timestamp mapper back end
// Tracks sequence and clock offset, then maps, caps and orders sample times.
// ----------------------------------------------------------------------------
`default_nettype none

module dhtm_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dhtm_pkg::t_work               i_work,
    input  wire dhtm_pkg::t_q_stat             i_q_stat,
    input  wire logic [dhtm_pkg::SLEW_W-1:0]   i_max_slew_ns,
    output logic                               o_pop,
    dhtm_out_if.source                         o_out
);

    localparam int NS_W   = dhtm_pkg::NS_W;
    localparam int SLEW_W = dhtm_pkg::SLEW_W;

    typedef enum logic [1:0] {
        SM_NONE   = 2'd0,
        SM_RAW    = 2'd1,
        SM_MAPPED = 2'd2
    } t_smode;

    typedef struct packed {
        t_smode                      smode;
        logic                        clr_sample;
        logic                        dup;
        logic                        was_reset;
        logic [NS_W-1:0]             offset;
        logic [dhtm_pkg::DNS_W-1:0]  dev_ns;
        logic [NS_W-1:0]             rx;
    } t_b1;

    // Tracking state.
    logic                        r_seq_known;
    logic [dhtm_pkg::SEQ_W-1:0]  r_last_seq;
    logic                        r_off_known;
    logic [NS_W-1:0]             r_offset;
    logic [NS_W-1:0]             r_last_sample;

    logic                        n_seq_known;
    logic [dhtm_pkg::SEQ_W-1:0]  n_last_seq;
    logic                        n_off_known;
    logic [NS_W-1:0]             n_offset;
    logic [NS_W-1:0]             n_last_sample;

    // Stage registers.
    logic                        r_b1_valid;
    t_b1                         r_b1;
    t_b1                         n_b1;
    logic                        r_out_valid;
    logic [NS_W-1:0]             r_out_sample;
    logic                        r_out_dup;
    logic                        r_out_reset;

    logic                        back_en;
    logic [dhtm_pkg::SEQ_W-1:0]  fwd;
    logic                        back_jump;
    logic                        is_dup;
    logic                        clr;
    logic                        base_known;
    logic [NS_W-1:0]             base_off;
    logic [NS_W:0]               diff;
    logic [SLEW_W-1:0]           step;
    logic [NS_W-1:0]             tracked;

    logic [NS_W-1:0]             last_eff;
    logic [NS_W:0]               mapped;
    logic [NS_W-1:0]             capped;
    logic [NS_W-1:0]             base_sample;
    logic [NS_W-1:0]             sample;

    // The whole back end advances together when the output can move.
    assign back_en = !r_out_valid || o_out.ready;
    assign o_pop   = back_en && !i_q_stat.empty;

    // Sequence check and offset tracking for the request at the queue head.
    always_comb begin
        fwd        = i_work.seq - r_last_seq;
        back_jump  = r_seq_known && (fwd > dhtm_pkg::BACKWARD_LIMIT);
        is_dup     = r_seq_known && (i_work.seq == r_last_seq);
        clr        = back_jump && (((i_work.action == dhtm_pkg::ACT_PACKET) && !is_dup)
                                   || (i_work.action == dhtm_pkg::ACT_PRIME));
        base_known = clr ? 1'b0 : r_off_known;
        base_off   = clr ? '0 : r_offset;

        // A lower estimate is taken at once, a higher one is slew limited.
        diff = {1'b0, i_work.cand} - {1'b0, base_off};
        if ((diff[NS_W-1:SLEW_W] != '0) || (diff[SLEW_W-1:0] > i_max_slew_ns)) begin
            step = i_max_slew_ns;
        end else begin
            step = diff[SLEW_W-1:0];
        end
        tracked = base_off + NS_W'(step);

        n_seq_known       = r_seq_known;
        n_last_seq        = r_last_seq;
        n_off_known       = base_known;
        n_offset          = base_off;
        n_b1.smode        = SM_NONE;
        n_b1.clr_sample   = clr;
        n_b1.dup          = 1'b0;
        n_b1.was_reset    = clr;
        n_b1.offset       = base_off;
        n_b1.dev_ns       = i_work.dev_ns;
        n_b1.rx           = i_work.rx;

        unique case (i_work.action)
            dhtm_pkg::ACT_PACKET: begin
                if (is_dup) begin
                    n_b1.dup = 1'b1;
                end else begin
                    n_seq_known = 1'b1;
                    n_last_seq  = i_work.seq;
                    if (i_work.has_stamp) begin
                        n_off_known = 1'b1;
                        if (!base_known || diff[NS_W]) begin
                            n_offset = i_work.cand;
                        end else begin
                            n_offset = tracked;
                        end
                        n_b1.smode = SM_MAPPED;
                    end else begin
                        n_b1.smode = SM_RAW;
                    end
                    n_b1.offset = n_offset;
                end
            end
            dhtm_pkg::ACT_PRIME: begin
                if (clr) begin
                    n_seq_known = 1'b0;
                end
                if (i_work.has_stamp && !base_known) begin
                    n_off_known = 1'b1;
                    n_offset    = i_work.cand;
                end
            end
            dhtm_pkg::ACT_RESET: begin
                n_seq_known     = 1'b0;
                n_last_seq      = '0;
                n_off_known     = 1'b0;
                n_offset        = '0;
                n_b1.clr_sample = 1'b1;
                n_b1.was_reset  = 1'b1;
            end
            dhtm_pkg::ACT_UNUSED: begin
                n_b1.clr_sample = 1'b0;
                n_b1.was_reset  = 1'b0;
            end
        endcase
    end

    // Map, cap at the receive time and force a strict increase.
    always_comb begin
        last_eff    = r_b1.clr_sample ? '0 : r_last_sample;
        mapped      = {1'b0, NS_W'(r_b1.dev_ns)} + {1'b0, r_b1.offset};
        capped      = (mapped < {1'b0, r_b1.rx}) ? mapped[NS_W-1:0] : r_b1.rx;
        base_sample = (r_b1.smode == SM_RAW) ? r_b1.rx : capped;
        if ((last_eff != '0) && (base_sample <= last_eff)) begin
            sample = (last_eff == dhtm_pkg::NS_MAX) ? dhtm_pkg::NS_MAX : last_eff + 1'b1;
        end else begin
            sample = base_sample;
        end
        n_last_sample = (r_b1.smode == SM_NONE) ? last_eff : sample;
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_known   <= 1'b0;
            r_last_seq    <= '0;
            r_off_known   <= 1'b0;
            r_offset      <= '0;
            r_last_sample <= '0;
            r_b1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (back_en) begin
            r_b1_valid  <= !i_q_stat.empty;
            r_out_valid <= r_b1_valid;
            if (!i_q_stat.empty) begin
                r_seq_known <= n_seq_known;
                r_last_seq  <= n_last_seq;
                r_off_known <= n_off_known;
                r_offset    <= n_offset;
            end
            if (r_b1_valid) begin
                r_last_sample <= n_last_sample;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (back_en) begin
            if (!i_q_stat.empty) begin
                r_b1 <= n_b1;
            end
            if (r_b1_valid) begin
                r_out_sample <= (r_b1.smode == SM_NONE) ? '0 : sample;
                r_out_dup    <= r_b1.dup;
                r_out_reset  <= r_b1.was_reset;
            end
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.sample_time_ns    = r_out_sample;
    assign o_out.dropped_duplicate = r_out_dup;
    assign o_out.timing_was_reset  = r_out_reset;

    a_offset_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_off_known |-> (r_offset == '0))
        else $error("offset held while unknown");

    a_dup_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dup) |-> ((r_out_sample == '0) && !r_out_reset))
        else $error("duplicate carries a sample or a timing reset");

    a_sample_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_en && r_b1_valid && (r_b1.smode != SM_NONE) && (last_eff != '0)
         && (last_eff != dhtm_pkg::NS_MAX)) |-> (sample > last_eff))
        else $error("sample time not strictly increasing");

endmodule

`default_nettype wire
